FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/smp_pkg.sv
// ---------------------------------------------------------------------------
// smp_pkg
// Shared constants, types and helpers for the square matrix power block.
// ---------------------------------------------------------------------------
package smp_pkg;

    localparam int MAX_ORDER = 8;
    localparam int CELLS     = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ORDER_W   = 4;
    localparam int DATA_W    = 32;

    localparam logic REG_ORDER = 1'b0;
    localparam logic REG_POWER = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_DECIDE,
        ST_SHIFT,
        ST_MUL,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_COPY,
        ST_COPY_END,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic {
        DST_ACCUM,
        DST_BASE
    } dst_t;

    // Row-major flat index of (row, col) for a matrix of order n
    function automatic logic [ADDR_W-1:0] flat_idx(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col,
                                                   input logic [ORDER_W-1:0] n);
        logic [CNT_W-1:0] t;
        t = CNT_W'(row) * CNT_W'(n) + CNT_W'(col);
        return t[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/smp_ram.sv
// ---------------------------------------------------------------------------
// smp_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module smp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: design/square_matrix_power.sv
// Load: one element word per cycle; the last element starts the computation.
// Compute: base cells past the load are zeroed, the accumulator set to identity;
// each matrix product is multiply-accumulated into scratch and copied back, up to
// 63 products for a 32-bit power, with a decide or shift step between products.
// Output: each result word is read and held until taken; no new input until done.
// Reset clears control state; matrix memories hold undefined data until written.
// ---------------------------------------------------------------------------
// square_matrix_power
// Raises a loaded square matrix to a configured power by square-and-multiply,
// with base, accumulator and product scratch held in synchronous RAMs.
// ---------------------------------------------------------------------------
module square_matrix_power import smp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DATA_W-1:0]   element,
    input  logic                final_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   value,
    output logic                final_out
);

    state_t               state_reg, state_next;
    dst_t                 dst_reg, dst_next;
    logic [ORDER_W-1:0]   order_reg;
    logic [DATA_W-1:0]    power_reg;
    logic [CNT_W-1:0]     lc_reg, lc_next;
    logic [DATA_W-1:0]    pl_reg, pl_next;
    logic [ORDER_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CNT_W-1:0]     flat_reg, flat_next;

    logic                 s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [ADDR_W-1:0]    s1_waddr_reg;
    logic                 s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [ADDR_W-1:0]    s2_waddr_reg;
    logic [DATA_W-1:0]    prod_reg, acc_reg, acc_sum;
    logic                 cp_valid_reg;
    logic [ADDR_W-1:0]    cp_addr_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_value_reg, out_value_next;
    logic                 out_final_reg, out_final_next;

    logic [ORDER_W-1:0]   n_now;
    logic [CNT_W-1:0]     cells_now, cells_c;
    logic [IDX_W-1:0]     last_idx;
    logic                 in_acc, out_acc, issue, issue_last, load_wr;
    logic [ADDR_W-1:0]    a_addr, b_addr;

    logic                 base_we, accum_we;
    logic [ADDR_W-1:0]    base_waddr, accum_waddr, accum_raddr;
    logic [DATA_W-1:0]    base_wdata, accum_wdata;
    logic [DATA_W-1:0]    base_rd_a, base_rd_b, accum_rd, scratch_rd, op_a;

    // Effective order and sizes
    always_comb
    begin
        if (order_reg == '0)
            n_now = ORDER_W'(1);
        else if (order_reg > ORDER_W'(MAX_ORDER))
            n_now = ORDER_W'(MAX_ORDER);
        else
            n_now = order_reg;
    end

    assign cells_now  = CNT_W'(n_now) * CNT_W'(n_now);
    assign cells_c    = CNT_W'(n_reg) * CNT_W'(n_reg);
    assign last_idx   = IDX_W'(n_reg - ORDER_W'(1));
    assign in_acc     = in_valid && !in_stall;
    assign out_acc    = out_valid_reg && !out_stall;
    assign issue      = (state_reg == ST_MUL);
    assign issue_last = (i_reg == last_idx) && (j_reg == last_idx) && (k_reg == last_idx);
    assign load_wr    = in_acc && (lc_reg < cells_now);
    assign a_addr     = flat_idx(i_reg, k_reg, n_reg);
    assign b_addr     = flat_idx(k_reg, j_reg, n_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_acc && final_in) state_next = ST_INIT;
            ST_INIT:
                if (flat_reg == cells_c - CNT_W'(1)) state_next = ST_DECIDE;
            ST_DECIDE:
                if (pl_reg == '0)    state_next = ST_OUT_RD;
                else if (pl_reg[0])  state_next = ST_MUL;
                else                 state_next = ST_SHIFT;
            ST_SHIFT:
                if ((pl_reg >> 1) != '0) state_next = ST_MUL;
                else                     state_next = ST_DECIDE;
            ST_MUL:
                if (issue_last) state_next = ST_DRAIN1;
            ST_DRAIN1:
                state_next = ST_DRAIN2;
            ST_DRAIN2:
                state_next = ST_COPY;
            ST_COPY:
                if (flat_reg == cells_c - CNT_W'(1)) state_next = ST_COPY_END;
            ST_COPY_END:
                state_next = (dst_reg == DST_ACCUM) ? ST_SHIFT : ST_DECIDE;
            ST_OUT_RD:
                state_next = ST_OUT_LD;
            ST_OUT_LD:
                state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (out_acc) state_next = out_final_reg ? ST_LOAD : ST_OUT_RD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Counters, exponent and output word
    always_comb
    begin
        lc_next        = lc_reg;
        pl_next        = pl_reg;
        n_next         = n_reg;
        dst_next       = dst_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        flat_next      = flat_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_wr) lc_next = lc_reg + CNT_W'(1);
                if (in_acc && final_in)
                begin
                    n_next    = n_now;
                    pl_next   = power_reg;
                    flat_next = '0;
                    i_next    = '0;
                    j_next    = '0;
                end
            end
            ST_INIT:
            begin
                flat_next = flat_reg + CNT_W'(1);
                if (j_reg == last_idx)
                begin
                    j_next = '0;
                    i_next = i_reg + IDX_W'(1);
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                if (flat_reg == cells_c - CNT_W'(1)) lc_next = '0;
            end
            ST_DECIDE:
            begin
                flat_next = '0;
                dst_next  = DST_ACCUM;
                i_next    = '0;
                j_next    = '0;
                k_next    = '0;
            end
            ST_SHIFT:
            begin
                pl_next  = pl_reg >> 1;
                dst_next = DST_BASE;
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
            end
            ST_MUL:
            begin
                if (k_reg == last_idx)
                begin
                    k_next = '0;
                    if (j_reg == last_idx)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN2:
                flat_next = '0;
            ST_COPY:
                flat_next = flat_reg + CNT_W'(1);
            ST_OUT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = accum_rd;
                out_final_next = (flat_reg == cells_c - CNT_W'(1));
            end
            ST_OUT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    flat_next      = flat_reg + CNT_W'(1);
                end
            end
            default:
            begin
                lc_next = lc_reg;
            end
        endcase
    end

    // Base memory write port: load, zero fill, copy back
    always_comb
    begin
        base_we    = 1'b0;
        base_waddr = lc_reg[ADDR_W-1:0];
        base_wdata = element;
        if (state_reg == ST_LOAD)
        begin
            base_we = load_wr;
        end
        else if (state_reg == ST_INIT)
        begin
            base_we    = (flat_reg >= lc_reg);
            base_waddr = flat_reg[ADDR_W-1:0];
            base_wdata = '0;
        end
        else if (cp_valid_reg && (dst_reg == DST_BASE))
        begin
            base_we    = 1'b1;
            base_waddr = cp_addr_reg;
            base_wdata = scratch_rd;
        end
    end

    // Accumulator memory write port: identity fill, copy back
    always_comb
    begin
        accum_we    = 1'b0;
        accum_waddr = flat_reg[ADDR_W-1:0];
        accum_wdata = (i_reg == j_reg) ? DATA_W'(1) : '0;
        if (state_reg == ST_INIT)
        begin
            accum_we = 1'b1;
        end
        else if (cp_valid_reg && (dst_reg == DST_ACCUM))
        begin
            accum_we    = 1'b1;
            accum_waddr = cp_addr_reg;
            accum_wdata = scratch_rd;
        end
    end

    assign accum_raddr = issue ? a_addr : flat_reg[ADDR_W-1:0];
    assign op_a        = (dst_reg == DST_ACCUM) ? accum_rd : base_rd_a;
    assign acc_sum     = s2_first_reg ? prod_reg : acc_reg + prod_reg;

    smp_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_base (
        .clk     (clk),
        .we      (base_we),
        .waddr   (base_waddr),
        .wdata   (base_wdata),
        .raddr_a (a_addr),
        .rdata_a (base_rd_a),
        .raddr_b (b_addr),
        .rdata_b (base_rd_b)
    );

    smp_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_accum (
        .clk     (clk),
        .we      (accum_we),
        .waddr   (accum_waddr),
        .wdata   (accum_wdata),
        .raddr_a (accum_raddr),
        .rdata_a (accum_rd),
        .raddr_b (accum_raddr),
        .rdata_b ()
    );

    smp_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_scratch (
        .clk     (clk),
        .we      (s2_valid_reg && s2_last_reg),
        .waddr   (s2_waddr_reg),
        .wdata   (acc_sum),
        .raddr_a (flat_reg[ADDR_W-1:0]),
        .rdata_a (scratch_rd),
        .raddr_b (flat_reg[ADDR_W-1:0]),
        .rdata_b ()
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            dst_reg       <= DST_ACCUM;
            order_reg     <= ORDER_W'(MAX_ORDER);
            power_reg     <= DATA_W'(1);
            lc_reg        <= '0;
            pl_reg        <= '0;
            n_reg         <= ORDER_W'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            flat_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            cp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dst_reg       <= dst_next;
            lc_reg        <= lc_next;
            pl_reg        <= pl_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            flat_reg      <= flat_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            cp_valid_reg  <= (state_reg == ST_COPY);
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_ORDER)) order_reg <= cfg_data[ORDER_W-1:0];
            if (cfg_we && (cfg_index == REG_POWER)) power_reg <= cfg_data;
        end
    end

    // Multiply-accumulate pipeline and output payload
    always_ff @(posedge clk)
    begin
        s1_first_reg  <= (k_reg == '0);
        s1_last_reg   <= (k_reg == last_idx);
        s1_waddr_reg  <= flat_idx(i_reg, j_reg, n_reg);
        s2_first_reg  <= s1_first_reg;
        s2_last_reg   <= s1_last_reg;
        s2_waddr_reg  <= s1_waddr_reg;
        prod_reg      <= op_a * base_rd_b;
        if (s2_valid_reg) acc_reg <= acc_sum;
        cp_addr_reg   <= flat_reg[ADDR_W-1:0];
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign final_out = out_final_reg;

endmodule

FILE: design/smp_checker.sv
// ---------------------------------------------------------------------------
// smp_checker
// Port-level checks on the square matrix power block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smp_checker import smp_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              final_in,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] value,
    input logic              final_out
);

    // Hold a stalled result word
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(final_out), "stalled result word changed")

    // Never take input while a result is shown
    `ASSERT_HOLD(a_no_overlap, !out_valid || in_stall, "input taken while result pending")

    // Stop taking input after the last element
    `ASSERT_NEXT(a_final_stall, in_valid && !in_stall && final_in, in_stall, "input taken after last element")

    // Drop valid after the last result word
    `ASSERT_NEXT(a_final_done, out_valid && !out_stall && final_out, !out_valid, "result after last word")

endmodule

bind square_matrix_power smp_checker u_smp_checker (.*);
